// ===== rtl/core/bss_pkg.sv =====
// Shared types and constants for the bounded stack with search.
`default_nettype none
package bss_pkg;

	localparam int DATA_W    = 32;
	localparam int CAP_W     = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
	localparam logic [DATA_W-1:0] NEG_ONE   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SEARCH
	} fsm_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	typedef struct packed {
		logic              vld;
		logic              hit;
		logic [DATA_W-1:0] key;
	} token_t;

endpackage
`default_nettype wire

// ===== rtl/core/bss_cell.sv =====
// One stack cell: holds an entry, shifts on push and pop, and checks a passing search key.
`default_nettype none
module bss_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bss_pkg::cell_ctl_t        ctl,
	input  wire logic [bss_pkg::DATA_W-1:0] prev_entry,
	input  wire logic                      prev_valid,
	input  wire logic [bss_pkg::DATA_W-1:0] next_entry,
	input  wire logic                      next_valid,
	output logic      [bss_pkg::DATA_W-1:0] entry,
	output logic                           valid,
	input  wire bss_pkg::token_t           tok_in,
	output bss_pkg::token_t                tok_out
);

	logic [bss_pkg::DATA_W-1:0] entry_q;
	logic                       valid_q;
	logic                       tok_vld_q;
	logic                       tok_hit_q;
	logic [bss_pkg::DATA_W-1:0] tok_key_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= prev_entry;
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				valid_q <= prev_valid;
			end else if (ctl.pop) begin
				valid_q <= next_valid;
			end
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_key_q <= tok_in.key;
		tok_hit_q <= tok_in.hit | (tok_in.vld & valid_q & (entry_q == tok_in.key));
	end

	assign entry       = entry_q;
	assign valid       = valid_q;
	assign tok_out.vld = tok_vld_q;
	assign tok_out.hit = tok_hit_q;
	assign tok_out.key = tok_key_q;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_stack_with_search.sv =====
// Top level of the bounded stack with search: control, result register and the cell chain.
//
//  channel  | dir | handshake                    | contents
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: value; tuser: mode
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: popped_value, found; tuser: status
//  cfg      | in  | cfg_we                       | cfg_wdata: capacity
//
// Push, pop, unused mode and a search of an empty stack load the result register in the cycle the word is accepted.
// A search of a nonempty stack sends the key down the cell chain, one cell a cycle,
// so its result is loaded once the key has passed through the last cell.
// Reset empties the stack and sets capacity to 64; entries themselves are not cleared.
// A new word is taken only while no search runs and the result register is free or
// being drained in the same cycle.
`default_nettype none
module bounded_stack_with_search #(
	parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bss_pkg::CAP_W-1:0]  cfg_wdata,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [31:0]                s_axis_tdata,  // [31:0] value
	input  wire logic [1:0]                 s_axis_tuser,  // [1:0] mode
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic      [39:0]                m_axis_tdata,  // [31:0] popped_value, [32] found
	output logic      [1:0]                 m_axis_tuser   // [1:0] status
);

	localparam int DW    = bss_pkg::DATA_W;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > bss_pkg::CAP_W) ? CNT_W : bss_pkg::CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [bss_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          count_q;
	bss_pkg::fsm_t             state_q, state_d;

	logic                      out_valid_q;
	logic [DW-1:0]             popped_q;
	logic                      found_q;
	bss_pkg::status_t          status_q;

	logic                      out_load;
	logic [DW-1:0]             popped_d;
	logic                      found_d;
	bss_pkg::status_t          status_d;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      srch_start;
	bss_pkg::mode_t            mode;
	bss_pkg::cell_ctl_t        ctl;

	logic [DW-1:0]             entry [DEPTH];
	logic                      valid [DEPTH];
	bss_pkg::token_t           tok   [DEPTH+1];

	assign mode   = bss_pkg::mode_t'(s_axis_tuser);
	assign accept = s_axis_tvalid & s_axis_tready;
	assign empty  = (count_q == '0);
	assign full   = (CMP_W'(count_q) >= CMP_W'(capacity_q)) || (CMP_W'(count_q) >= DEPTH_C);

	assign s_axis_tready = (state_q == bss_pkg::FSM_IDLE) & (~out_valid_q | m_axis_tready);

	assign ctl.push = accept & (mode == bss_pkg::MODE_PUSH) & ~full;
	assign ctl.pop  = accept & (mode == bss_pkg::MODE_POP) & ~empty;

	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		popped_d   = bss_pkg::NEG_ONE;
		found_d    = 1'b0;
		status_d   = bss_pkg::ST_OK;
		srch_start = 1'b0;
		case (state_q)
			bss_pkg::FSM_IDLE: begin
				if (accept) begin
					case (mode)
						bss_pkg::MODE_PUSH: begin
							out_load = 1'b1;
							if (full) begin
								status_d = bss_pkg::ST_FULL;
							end
						end
						bss_pkg::MODE_POP: begin
							out_load = 1'b1;
							if (empty) begin
								status_d = bss_pkg::ST_EMPTY;
							end else begin
								popped_d = entry[0];
							end
						end
						bss_pkg::MODE_SEARCH: begin
							if (empty) begin
								out_load = 1'b1;
								status_d = bss_pkg::ST_EMPTY;
							end else begin
								srch_start = 1'b1;
								state_d    = bss_pkg::FSM_SEARCH;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			bss_pkg::FSM_SEARCH: begin
				if (tok[DEPTH].vld) begin
					out_load = 1'b1;
					found_d  = tok[DEPTH].hit;
					state_d  = bss_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = bss_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= bss_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (ctl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			popped_q <= popped_d;
			found_q  <= found_d;
			status_q <= status_d;
		end
	end

	assign tok[0].vld = srch_start;
	assign tok[0].hit = 1'b0;
	assign tok[0].key = s_axis_tdata;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] prev_entry;
		logic          prev_valid;
		logic [DW-1:0] next_entry;
		logic          next_valid;

		if (i == 0) begin : g_top
			assign prev_entry = s_axis_tdata;
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_entry = entry[i-1];
			assign prev_valid = valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_bot
			assign next_entry = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_entry = entry[i+1];
			assign next_valid = valid[i+1];
		end

		bss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_entry (prev_entry),
			.prev_valid (prev_valid),
			.next_entry (next_entry),
			.next_valid (next_valid),
			.entry      (entry[i]),
			.valid      (valid[i]),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, found_q, popped_q};
	assign m_axis_tuser  = status_q;

endmodule
`default_nettype wire
